[hw/rtl/dcgr_pkg.sv]
`default_nettype none

package dcgr_pkg;

    localparam int COUNT_W   = 31;
    localparam int PAD_W     = 32;
    localparam int ROW_W     = 32;
    localparam int ROWS      = 8;
    localparam int DIGITS    = 6;
    localparam int BCD_W     = DIGITS * 4;
    localparam int GLYPH_W   = 5;
    localparam int DD_STAGES = 4;
    localparam int DD_BITS   = PAD_W / DD_STAGES;

    // left edge of each glyph cell
    localparam int COL_D5    = 0;
    localparam int COL_D4    = 5;
    localparam int COL_D3    = 10;
    localparam int COL_COMMA = 15;
    localparam int COL_D2    = 18;
    localparam int COL_D1    = 23;
    localparam int COL_D0    = 28;

    // thresholds for leading digit blanking
    localparam logic [COUNT_W-1:0] LIM_D1 = COUNT_W'(9);
    localparam logic [COUNT_W-1:0] LIM_D2 = COUNT_W'(99);
    localparam logic [COUNT_W-1:0] LIM_D3 = COUNT_W'(999);
    localparam logic [COUNT_W-1:0] LIM_D4 = COUNT_W'(9999);
    localparam logic [COUNT_W-1:0] LIM_D5 = COUNT_W'(99999);

    typedef logic [ROWS-1:0][7:0] glyph_t;
    typedef logic [BCD_W-1:0]     bcd_t;
    typedef logic [ROW_W-1:0]     row_t;

    localparam glyph_t COMMA_GLYPH = {8'h80, 8'h40, 8'hc0, 8'h00,
                                      8'h00, 8'h00, 8'h00, 8'h00};

    // font: element [r] is glyph row r
    function automatic glyph_t digit_glyph(input logic [3:0] d);
        glyph_t g;
        case (d)
            4'd0:    g = {8'h00, 8'h60, 8'h90, 8'h90, 8'h90, 8'h90, 8'h90, 8'h60};
            4'd1:    g = {8'h00, 8'h70, 8'h20, 8'h20, 8'h20, 8'h20, 8'h60, 8'h20};
            4'd2:    g = {8'h00, 8'hf0, 8'h80, 8'h40, 8'h20, 8'h10, 8'h90, 8'h60};
            4'd3:    g = {8'h00, 8'h60, 8'h90, 8'h10, 8'h60, 8'h10, 8'h90, 8'h60};
            4'd4:    g = {8'h00, 8'h20, 8'h20, 8'h20, 8'hf0, 8'ha0, 8'ha0, 8'h80};
            4'd5:    g = {8'h00, 8'h60, 8'h90, 8'h10, 8'h10, 8'he0, 8'h80, 8'hf0};
            4'd6:    g = {8'h00, 8'h60, 8'h90, 8'h90, 8'he0, 8'h80, 8'h90, 8'h60};
            4'd7:    g = {8'h00, 8'h40, 8'h40, 8'h40, 8'h40, 8'h20, 8'h10, 8'hf0};
            4'd8:    g = {8'h00, 8'h60, 8'h90, 8'h90, 8'h60, 8'h90, 8'h90, 8'h60};
            4'd9:    g = {8'h00, 8'h60, 8'h90, 8'h10, 8'h70, 8'h90, 8'h90, 8'h60};
            default: g = '0;
        endcase
        return g;
    endfunction

    // one double-dabble step: add 3 to digits >= 5, then shift in a bit.
    // the carry out of the top digit is dropped, which keeps value mod 1e6.
    function automatic bcd_t dd_step(input bcd_t b, input logic bin);
        bcd_t t;
        t = b;
        for (int d = 0; d < DIGITS; d++) begin
            if (t[4*d +: 4] >= 4'd5) begin
                t[4*d +: 4] = t[4*d +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], bin};
    endfunction

    // draw glyph row g at column x0, clipping past the right edge
    function automatic row_t put_glyph(input row_t row, input logic [7:0] g, input int x0);
        row_t r;
        r = row;
        for (int j = 0; j < GLYPH_W; j++) begin
            if (x0 + j < ROW_W) begin
                r[x0 + j] = g[7 - j];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/decimal_count_glyph_render_core.sv]
// Pipeline: 5 register stages (4 conversion + 1 render) between the input accept and out_valid.
// Throughput: one item per cycle; the pipeline only holds when the output item is not taken.
// The binary-to-decimal conversion is double-dabble, 8 input bits per stage, which sets depth.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data registers are not reset.
`default_nettype none

module decimal_count_glyph_render_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [dcgr_pkg::COUNT_W-1:0]    count,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [dcgr_pkg::ROW_W-1:0]           row_0,
    output logic [dcgr_pkg::ROW_W-1:0]           row_1,
    output logic [dcgr_pkg::ROW_W-1:0]           row_2,
    output logic [dcgr_pkg::ROW_W-1:0]           row_3,
    output logic [dcgr_pkg::ROW_W-1:0]           row_4,
    output logic [dcgr_pkg::ROW_W-1:0]           row_5,
    output logic [dcgr_pkg::ROW_W-1:0]           row_6,
    output logic [dcgr_pkg::ROW_W-1:0]           row_7
);

    localparam int NS = dcgr_pkg::DD_STAGES;
    localparam int NB = dcgr_pkg::DD_BITS;

    // whole pipe moves together; it holds only while the output item waits
    logic adv;

    // conversion stages
    logic                              dd_valid_reg [NS];
    dcgr_pkg::bcd_t                    bcd_reg      [NS];
    dcgr_pkg::bcd_t                    bcd_next     [NS];
    logic [dcgr_pkg::COUNT_W-1:0]      cnt_reg      [NS-1];
    // show flags: [5:1] digit k shown, [0] comma shown
    logic [5:0]                        show_reg     [NS];
    logic [5:0]                        show_in;
    logic [dcgr_pkg::PAD_W-1:0]        src          [NS];
    dcgr_pkg::bcd_t                    bcd_src      [NS];

    // render stage
    logic                              out_valid_reg;
    dcgr_pkg::row_t                    rows_reg     [dcgr_pkg::ROWS];
    dcgr_pkg::row_t                    rows_next    [dcgr_pkg::ROWS];

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // blanking decisions come straight from the binary count
    assign show_in[0] = count > dcgr_pkg::LIM_D3;
    assign show_in[1] = count > dcgr_pkg::LIM_D1;
    assign show_in[2] = count > dcgr_pkg::LIM_D2;
    assign show_in[3] = count > dcgr_pkg::LIM_D3;
    assign show_in[4] = count > dcgr_pkg::LIM_D4;
    assign show_in[5] = count > dcgr_pkg::LIM_D5;

    // each stage shifts in the next NB bits, MSB first
    always_comb begin
        dcgr_pkg::bcd_t acc;
        src[0]     = {1'b0, count};
        bcd_src[0] = '0;
        for (int s = 1; s < NS; s++) begin
            src[s]     = {1'b0, cnt_reg[s-1]};
            bcd_src[s] = bcd_reg[s-1];
        end
        for (int s = 0; s < NS; s++) begin
            acc = bcd_src[s];
            for (int i = 0; i < NB; i++) begin
                acc = dcgr_pkg::dd_step(acc, src[s][dcgr_pkg::PAD_W - 1 - NB*s - i]);
            end
            bcd_next[s] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int s = 0; s < NS; s++) begin
                dd_valid_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv) begin
            dd_valid_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++) begin
                dd_valid_reg[s] <= dd_valid_reg[s-1];
            end
            out_valid_reg <= dd_valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            bcd_reg[0]  <= bcd_next[0];
            show_reg[0] <= show_in;
            for (int s = 1; s < NS; s++) begin
                bcd_reg[s]  <= bcd_next[s];
                show_reg[s] <= show_reg[s-1];
            end
            cnt_reg[0] <= count;
            for (int s = 1; s < NS - 1; s++) begin
                cnt_reg[s] <= cnt_reg[s-1];
            end
            for (int r = 0; r < dcgr_pkg::ROWS; r++) begin
                rows_reg[r] <= rows_next[r];
            end
        end
    end

    // render: draw in order d5, d4, d3, comma, d2, d1, d0; later draws win
    always_comb begin
        dcgr_pkg::glyph_t g5, g4, g3, gc, g2, g1, g0;
        dcgr_pkg::bcd_t   b;
        logic [5:0]       sh;
        dcgr_pkg::row_t   acc;
        b  = bcd_reg[NS-1];
        sh = show_reg[NS-1];
        g5 = sh[5] ? dcgr_pkg::digit_glyph(b[23:20]) : '0;
        g4 = sh[4] ? dcgr_pkg::digit_glyph(b[19:16]) : '0;
        g3 = sh[3] ? dcgr_pkg::digit_glyph(b[15:12]) : '0;
        gc = sh[0] ? dcgr_pkg::COMMA_GLYPH : '0;
        g2 = sh[2] ? dcgr_pkg::digit_glyph(b[11:8])  : '0;
        g1 = sh[1] ? dcgr_pkg::digit_glyph(b[7:4])   : '0;
        g0 = dcgr_pkg::digit_glyph(b[3:0]);   // units always shows
        for (int r = 0; r < dcgr_pkg::ROWS; r++) begin
            acc = '0;
            acc = dcgr_pkg::put_glyph(acc, g5[r], dcgr_pkg::COL_D5);
            acc = dcgr_pkg::put_glyph(acc, g4[r], dcgr_pkg::COL_D4);
            acc = dcgr_pkg::put_glyph(acc, g3[r], dcgr_pkg::COL_D3);
            acc = dcgr_pkg::put_glyph(acc, gc[r], dcgr_pkg::COL_COMMA);
            acc = dcgr_pkg::put_glyph(acc, g2[r], dcgr_pkg::COL_D2);
            acc = dcgr_pkg::put_glyph(acc, g1[r], dcgr_pkg::COL_D1);
            acc = dcgr_pkg::put_glyph(acc, g0[r], dcgr_pkg::COL_D0);
            rows_next[r] = acc;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_0     = rows_reg[0];
    assign row_1     = rows_reg[1];
    assign row_2     = rows_reg[2];
    assign row_3     = rows_reg[3];
    assign row_4     = rows_reg[4];
    assign row_5     = rows_reg[5];
    assign row_6     = rows_reg[6];
    assign row_7     = rows_reg[7];

endmodule

`default_nettype wire
